[rtl/core/plfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plfs_pkg
// Shared types and constants of the palette limited frame splitter.
// ----------------------------------------------------------------------------
package plfs_pkg;

  localparam int unsigned DefMaxPixels    = 65536;
  localparam int unsigned DefPaletteDepth = 255;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned FrameW    = 16;
  localparam int unsigned PalCountW = 8;
  localparam int unsigned PixCfgW   = 17;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [PixCfgW-1:0]   ImagePixelsRst  = PixCfgW'(65536);
  localparam logic [PalCountW-1:0] PaletteLimitRst = PalCountW'(255);
  localparam logic [ColorW-1:0]    TranspColorRst  = 24'hDDFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_PIXELS  = 2'd0,
    CFG_PALETTE_LIMIT = 2'd1,
    CFG_TRANSP_COLOR  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [ColorW-1:0] out_color;
    logic              is_transparent;
    logic              pass_end;
    logic              image_done;
    logic [FrameW-1:0] frame_index;
  } pix_out_t;

  // Palette lookup control for one pixel
  typedef struct packed {
    logic lookup;    // pixel not yet done, look up / reserve its color
    logic pass_end;  // pixel closes the pass, empty the palette
  } pal_ctrl_t;

endpackage : plfs_pkg
`default_nettype wire

[rtl/core/plfs_palette.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plfs_palette
// Colors reserved in the current pass, with a parallel match over all entries.
// ----------------------------------------------------------------------------
module plfs_palette #(
  parameter int unsigned PALETTE_DEPTH = plfs_pkg::DefPaletteDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [plfs_pkg::ColorW-1:0]    color_i,
  input  wire logic [plfs_pkg::PalCountW-1:0] limit_i,
  input  wire plfs_pkg::pal_ctrl_t            ctrl_i,
  output logic                                known_o
);
  import plfs_pkg::*;

  logic [ColorW-1:0]    pal_q [PALETTE_DEPTH];
  logic [PalCountW-1:0] count_q, count_d;
  logic [PalCountW-1:0] limit_eff;
  logic                 hit;
  logic                 reserve;

  assign limit_eff = (limit_i > PalCountW'(PALETTE_DEPTH)) ? PalCountW'(PALETTE_DEPTH) : limit_i;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      if ((PalCountW'(i) < count_q) && (pal_q[i] == color_i)) begin
        hit = 1'b1;
      end
    end
  end

  assign reserve = ctrl_i.lookup && !hit && (count_q < limit_eff);
  assign known_o = hit || reserve;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.pass_end) begin
      count_d = '0;
    end else if (reserve) begin
      count_d = count_q + PalCountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // entries hold no reset; only entries below count_q take part in a match
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      if (reserve && (count_q == PalCountW'(i))) begin
        pal_q[i] <= color_i;
      end
    end
  end

endmodule : plfs_palette
`default_nettype wire

[rtl/core/plfs_done_map.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plfs_done_map
// One bit per pixel position, read one position ahead of its use.
// ----------------------------------------------------------------------------
module plfs_done_map #(
  parameter int unsigned MAX_PIXELS = plfs_pkg::DefMaxPixels,
  parameter int unsigned AddrW      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic             wr_data_i,
  output logic                  done_o
);
  import plfs_pkg::*;

  logic             mem [MAX_PIXELS];
  logic             rd_data_q;
  logic             fwd_q, fwd_data_q;
  logic             rd_ok_q;
  // fill mark: positions below it have been written at least once
  logic [AddrW:0]   fill_q, fill_d;

  // positions are visited in order from zero, so the fill mark stands in for
  // clearing the whole map after reset
  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && ({1'b0, wr_addr_i} >= fill_q)) begin
      fill_d = {1'b0, wr_addr_i} + (AddrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q  <= mem[rd_addr_i];
    fwd_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      fwd_q   <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      fwd_q   <= wr_en_i && (wr_addr_i == rd_addr_i);
      rd_ok_q <= ({1'b0, rd_addr_i} < fill_d);
    end
  end

  assign done_o = rd_ok_q && (fwd_q ? fwd_data_q : rd_data_q);

endmodule : plfs_done_map
`default_nettype wire

[rtl/core/palette_limited_frame_splitter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_limited_frame_splitter
// Replays an RGB image once per pass and emits frames of limited palette.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock unless the output stalls, and returns one
// result beat per pixel via the input register, then the result register.
// The palette match compares all reserved colors in parallel, and the done
// map is read at the next pixel position while the current one is written,
// so no pixel waits on memory. The done map needs no clearing time after
// reset; a fill mark tracks which positions hold data.
// Write configuration only while no beat is in flight; a new image needs a
// reset.
module palette_limited_frame_splitter #(
  parameter int unsigned MAX_PIXELS    = plfs_pkg::DefMaxPixels,
  parameter int unsigned PALETTE_DEPTH = plfs_pkg::DefPaletteDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire plfs_pkg::pix_in_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output plfs_pkg::pix_out_t                out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [plfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [plfs_pkg::CfgDataW-1:0] cfg_data_i
);
  import plfs_pkg::*;

  localparam int unsigned PosW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CmpW = (PosW + 1 > PixCfgW) ? PosW + 1 : PixCfgW;

  // configuration
  logic [PixCfgW-1:0]   pixels_q;
  logic [PalCountW-1:0] limit_q;
  logic [ColorW-1:0]    transp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_q <= ImagePixelsRst;
      limit_q  <= PaletteLimitRst;
      transp_q <= TranspColorRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_PIXELS:  pixels_q <= cfg_data_i[PixCfgW-1:0];
        CFG_PALETTE_LIMIT: limit_q  <= cfg_data_i[PalCountW-1:0];
        CFG_TRANSP_COLOR:  transp_q <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic    s1_valid_q;
  pix_in_t s1_data_q;
  logic    advance;
  logic    accept;

  assign advance    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= in_data_i;
    end
  end

  // per-pixel logic
  logic [ColorW-1:0] color;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              colored_q, colored_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [CmpW-1:0]   pixels_eff;
  logic              last;
  logic              done_bit;
  logic              known;
  logic              emitted;
  pal_ctrl_t         pal_ctrl;

  assign color = {s1_data_q.red, s1_data_q.green, s1_data_q.blue};

  always_comb begin
    pixels_eff = CmpW'(pixels_q);
    if (pixels_q == '0) begin
      pixels_eff = CmpW'(1);
    end else if (CmpW'(pixels_q) > CmpW'(MAX_PIXELS)) begin
      pixels_eff = CmpW'(MAX_PIXELS);
    end
  end

  assign last = (CmpW'(pos_q) + CmpW'(1)) >= pixels_eff;

  assign pal_ctrl.lookup   = advance && !done_bit;
  assign pal_ctrl.pass_end = advance && last;
  assign emitted           = pal_ctrl.lookup && known;

  plfs_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .color_i (color),
    .limit_i (limit_q),
    .ctrl_i  (pal_ctrl),
    .known_o (known)
  );

  plfs_done_map #(
    .MAX_PIXELS(MAX_PIXELS),
    .AddrW     (PosW)
  ) u_done_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (pos_d),
    .wr_en_i   (advance),
    .wr_addr_i (pos_q),
    .wr_data_i (done_bit || emitted),
    .done_o    (done_bit)
  );

  always_comb begin
    pos_d     = pos_q;
    colored_d = colored_q;
    frame_d   = frame_q;
    if (advance) begin
      if (last) begin
        pos_d     = '0;
        colored_d = 1'b0;
        frame_d   = frame_q + FrameW'(1);
      end else begin
        pos_d     = pos_q + PosW'(1);
        colored_d = colored_q || emitted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      colored_q <= 1'b0;
      frame_q   <= '0;
    end else begin
      pos_q     <= pos_d;
      colored_q <= colored_d;
      frame_q   <= frame_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_o.out_color      <= emitted ? color : transp_q;
      out_data_o.is_transparent <= !emitted;
      out_data_o.pass_end       <= last;
      out_data_o.image_done     <= last && !(colored_q || emitted);
      out_data_o.frame_index    <= frame_q;
    end
  end

endmodule : palette_limited_frame_splitter
`default_nettype wire

[bench/tb_palette_limited_frame_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_limited_frame_splitter
// Self-checking bench for the palette limited frame splitter.
// ----------------------------------------------------------------------------
// Pixels go in as bursts with random gaps, and results come back under a
// stall pattern that includes one long hold-off. A scoreboard predicts each
// result beat from its own done map, palette and pass counters, and compares
// every field. Configuration changes between phases, covering the clamped
// pixel counts, a zero palette limit and mid-pass pixel count changes.
module tb_palette_limited_frame_splitter;
  import plfs_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned SettleCyc  = 4;
  localparam int unsigned HoldCyc    = 300;
  localparam int unsigned NumPhases  = 18;

  class frame_split_sb;
    bit                   done_map [DefMaxPixels];
    logic [ColorW-1:0]    palette [$];
    int unsigned          pix_pos;
    bit                   colored;
    logic [FrameW-1:0]    frame_cnt;
    logic [PixCfgW-1:0]   cfg_pixels;
    logic [PalCountW-1:0] cfg_limit;
    logic [ColorW-1:0]    cfg_transp;
    pix_out_t             pending_px [$];
    int unsigned          errors;

    function new();
      pix_pos    = 0;
      colored    = 1'b0;
      frame_cnt  = '0;
      cfg_pixels = ImagePixelsRst;
      cfg_limit  = PaletteLimitRst;
      cfg_transp = TranspColorRst;
      errors     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_IMAGE_PIXELS:  cfg_pixels = data[PixCfgW-1:0];
        CFG_PALETTE_LIMIT: cfg_limit  = data[PalCountW-1:0];
        CFG_TRANSP_COLOR:  cfg_transp = data[ColorW-1:0];
        default: ;
      endcase
    endfunction

    // Predict the result beat of one accepted pixel and advance the pass.
    function void note_pixel(pix_in_t px);
      logic [ColorW-1:0] color;
      int unsigned       pixels;
      int unsigned       limit;
      int unsigned       pos;
      bit                known;
      bit                emitted;
      bit                last;
      pix_out_t          exp_px;
      color   = {px.red, px.green, px.blue};
      pixels  = cfg_pixels;
      limit   = cfg_limit;
      pos     = pix_pos;
      known   = 1'b0;
      emitted = 1'b0;
      if (pixels == 0) pixels = 1;
      if (pixels > DefMaxPixels) pixels = DefMaxPixels;
      if (limit > DefPaletteDepth) limit = DefPaletteDepth;
      if (pos >= DefMaxPixels) pos = DefMaxPixels - 1;
      if (!done_map[pos]) begin
        foreach (palette[i]) begin
          if (palette[i] == color) known = 1'b1;
        end
        if (!known && palette.size() < limit) begin
          palette.push_back(color);
          known = 1'b1;
        end
        if (known) begin
          done_map[pos] = 1'b1;
          colored       = 1'b1;
          emitted       = 1'b1;
        end
      end
      last = (pos >= pixels - 1);
      exp_px.out_color      = emitted ? color : cfg_transp;
      exp_px.is_transparent = !emitted;
      exp_px.pass_end       = last;
      exp_px.image_done     = last && !colored;
      exp_px.frame_index    = frame_cnt;
      pending_px.push_back(exp_px);
      if (last) begin
        pix_pos = 0;
        palette.delete();
        colored = 1'b0;
        frame_cnt++;
      end else begin
        pix_pos = pos + 1;
      end
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (pending_px.size() == 0) begin
        $error("result beat with nothing pending: %h", got);
        errors++;
        return;
      end
      want = pending_px.pop_front();
      if (got.out_color !== want.out_color) begin
        $error("out_color: expected %h, got %h", want.out_color, got.out_color);
        errors++;
      end
      if (got.is_transparent !== want.is_transparent) begin
        $error("is_transparent: expected %b, got %b", want.is_transparent,
               got.is_transparent);
        errors++;
      end
      if (got.pass_end !== want.pass_end) begin
        $error("pass_end: expected %b, got %b", want.pass_end, got.pass_end);
        errors++;
      end
      if (got.image_done !== want.image_done) begin
        $error("image_done: expected %b, got %b", want.image_done, got.image_done);
        errors++;
      end
      if (got.frame_index !== want.frame_index) begin
        $error("frame_index: expected %0d, got %0d", want.frame_index,
               got.frame_index);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  pix_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  pix_out_t            out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  frame_split_sb       sb;
  bit                  hold_req;
  int unsigned         cycle_cnt;
  logic [ColorW-1:0]   color_pool [8];
  int unsigned         pool_size;

  palette_limited_frame_splitter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(out_valid_o)) begin
        $error("out_valid_o is unknown");
        sb.errors++;
      end else if (out_valid_o && !out_stall_i) begin
        sb.check_pixel(out_data_o);
      end
    end
  end

  // Receiver: free, sparse and solid stall stretches, plus one long hold-off.
  initial begin
    int unsigned seg_left;
    int unsigned seg_kind;
    seg_left    = 0;
    seg_kind    = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCyc) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 2);
          seg_left = (seg_kind == 2) ? $urandom_range(1, 6) : $urandom_range(1, 40);
        end
        seg_left--;
        case (seg_kind)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 2) == 0);
          default: out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_pixel(input pix_in_t px);
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_pixel(px);
  endtask

  task automatic send_color(input logic [ColorW-1:0] c);
    send_pixel(pix_in_t'(c));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] pix,
                            input logic [CfgDataW-1:0] lim,
                            input logic [CfgDataW-1:0] tc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IMAGE_PIXELS;
    cfg_data_i <= pix;
    @(posedge clk_i);
    sb.write_reg(CFG_IMAGE_PIXELS, pix);
    cfg_idx_i  <= CFG_PALETTE_LIMIT;
    cfg_data_i <= lim;
    @(posedge clk_i);
    sb.write_reg(CFG_PALETTE_LIMIT, lim);
    cfg_idx_i  <= CFG_TRANSP_COLOR;
    cfg_data_i <= tc;
    @(posedge clk_i);
    sb.write_reg(CFG_TRANSP_COLOR, tc);
    cfg_we_i <= 1'b0;
  endtask

  function automatic pix_in_t pick_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return pix_in_t'($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
    if (sel < 3) return pix_in_t'(ColorW'($urandom()));
    return pix_in_t'(color_pool[$urandom_range(0, pool_size - 1)]);
  endfunction

  // Bursts of random length with random gaps, unless steady.
  task automatic offer_pixels(input int unsigned count, input bit steady);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (!steady && burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      if (burst_left > 0) burst_left--;
      send_pixel(pick_pixel());
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] pc;
    logic [CfgDataW-1:0] lc;
    logic [CfgDataW-1:0] tc;
    sb         = new();
    hold_req   = 1'b0;
    cycle_cnt  = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_IMAGE_PIXELS;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config; an emitted pixel equal to the transparent color
    send_color(24'hDDFFFF);
    send_color(24'h000000);
    send_color(24'hFFFFFF);
    send_color(24'hFF0000);
    send_color(24'h00FF00);
    send_color(24'h0000FF);
    send_color(24'h000000);
    send_color(24'hDDFFFF);
    wait_idle();

    // Pixel count lowered mid-pass, single color palette
    set_config(24'd3, 24'd1, 24'h000000);
    repeat (3) begin
      send_color(24'h123456);
      send_color(24'hABCDEF);
    end
    wait_idle();

    // Zero pixel count and zero palette limit
    set_config(24'd0, 24'd0, 24'hFFFFFF);
    repeat (3) send_color(24'h5A5A5A);
    wait_idle();

    // Oversized pixel counts clamp to the maximum
    set_config(24'h01FFFF, 24'd255, 24'hDDFFFF);
    send_color(24'hA5A5A5);
    send_color(24'h5A5A5A);
    wait_idle();
    set_config(24'hFFFFFF, 24'd255, 24'h010203);
    send_color(24'hA5A5A5);
    send_color(24'h777777);
    wait_idle();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case ($urandom_range(0, 11))
        0: pc = 24'd0;
        1: pc = 24'd65536;
        2: pc = 24'h01FFFF;
        3: pc = CfgDataW'($urandom_range(65537, 24'hFFFFFF));
        4, 5, 6: pc = CfgDataW'($urandom_range(1, 8));
        default: pc = CfgDataW'($urandom_range(9, 400));
      endcase
      case ($urandom_range(0, 7))
        0: lc = 24'd0;
        1: lc = 24'd255;
        2: lc = CfgDataW'($urandom_range(0, 24'hFFFFFF));
        default: lc = CfgDataW'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 3))
        0: tc = 24'h000000;
        1: tc = 24'hFFFFFF;
        default: tc = CfgDataW'($urandom_range(0, 24'hFFFFFF));
      endcase
      pool_size = $urandom_range(1, 8);
      foreach (color_pool[i]) color_pool[i] = ColorW'($urandom_range(0, 24'hFFFFFF));
      if ($urandom_range(0, 3) == 0) color_pool[0] = tc;
      set_config(pc, lc, tc);
      if (ph == 4) hold_req = 1'b1;
      offer_pixels($urandom_range(100, 130), $urandom_range(0, 3) == 0);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
